### src/dlrm_pkg.sv
// ----------------------------------------------------------------------------
// dlrm_pkg
// Shared types and codes of the debug link request master: command, opcode,
// result kind and status codes, register indexes and the job descriptor that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dlrm_pkg;

    // queue depth between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // input item kinds
    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_LINK    = 2'd1;
    localparam logic [1:0] CMD_WDATA   = 2'd2;

    // request opcodes
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_RDATA  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // transfer status codes
    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // configuration register indexes and reset values
    localparam logic CFG_ATTN = 1'b0;
    localparam logic CFG_SYNC = 1'b1;
    localparam logic [7:0] ATTN_RESET = 8'h01;
    localparam logic [7:0] SYNC_RESET = 8'h40;

    // saturation limit of the transfer counters
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // job types
    localparam logic JOB_SINGLE = 1'b0;  // one result, given as is
    localparam logic JOB_HEADER = 1'b1;  // opcode burst after sync

    // job descriptor; a header job carries the length in value
    typedef struct packed {
        logic        jtype;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [1:0]  status;
        logic [1:0]  op;
        logic [15:0] address;
        logic [15:0] good;
        logic [15:0] bad;
    } job_t;

endpackage

### src/dlrm_front.sv
// ----------------------------------------------------------------------------
// dlrm_front
// Front end: accepts input items, runs the request phase machine, keeps the
// checksum and transfer counters and pushes one job per producing item.
// ----------------------------------------------------------------------------
module dlrm_front
    import dlrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [1:0]  in_op,
    input  logic [15:0] in_address,
    input  logic [7:0]  in_length,
    input  logic [7:0]  in_byte,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    // phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SYNC  = 3'd1;
    localparam logic [2:0] PH_READ  = 3'd2;
    localparam logic [2:0] PH_WRITE = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [7:0]  attn_reg;
    logic [7:0]  sync_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  pend_op_reg, pend_op_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] good_reg, good_next;
    logic [15:0] bad_reg, bad_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  len_reg, len_next;
    logic        accept;
    logic [7:0]  left_dec;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign left_dec = left_reg - 8'd1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attn_reg <= ATTN_RESET;
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ATTN)
                attn_reg <= cfg_wdata;
            else
                sync_reg <= cfg_wdata;
        end
    end

    // phase machine and job build
    always_comb
    begin
        phase_next   = phase_reg;
        pend_op_next = pend_op_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        push         = 1'b0;
        push_job     = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (in_cmd == CMD_REQUEST)
                    begin
                        pend_op_next    = in_op;
                        addr_next       = in_address;
                        len_next        = in_length;
                        push            = 1'b1;
                        push_job.jtype  = JOB_SINGLE;
                        push_job.kind   = KIND_TX;
                        push_job.value  = attn_reg;
                        phase_next      = PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (in_cmd == CMD_LINK && in_byte == sync_reg)
                    begin
                        push             = 1'b1;
                        push_job.jtype   = JOB_HEADER;
                        push_job.op      = pend_op_reg;
                        push_job.address = addr_reg;
                        push_job.value   = len_reg;
                        if (pend_op_reg == OP_READ || pend_op_reg == OP_WRITE)
                        begin
                            if (len_reg == 8'd0)
                                phase_next = PH_IDLE;
                            else
                            begin
                                left_next  = len_reg;
                                sum_next   = len_reg;
                                phase_next = (pend_op_reg == OP_READ) ? PH_READ : PH_WRITE;
                            end
                        end
                        else
                            phase_next = PH_IDLE;
                    end
                end
                PH_READ, PH_WRITE:
                begin
                    if ((phase_reg == PH_READ && in_cmd == CMD_LINK) ||
                        (phase_reg == PH_WRITE && in_cmd == CMD_WDATA))
                    begin
                        push           = 1'b1;
                        push_job.jtype = JOB_SINGLE;
                        push_job.kind  = (phase_reg == PH_READ) ? KIND_RDATA : KIND_TX;
                        push_job.value = in_byte;
                        sum_next       = sum_reg + in_byte;
                        left_next      = left_dec;
                        if (left_dec == 8'd0)
                            phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (in_cmd == CMD_LINK)
                    begin
                        push           = 1'b1;
                        push_job.jtype = JOB_SINGLE;
                        push_job.kind  = KIND_STATUS;
                        if (in_byte == sum_reg)
                        begin
                            if (good_reg != COUNT_MAX)
                                good_next = good_reg + 16'd1;
                            push_job.status = ST_GOOD;
                        end
                        else
                        begin
                            if (bad_reg != COUNT_MAX)
                                bad_next = bad_reg + 16'd1;
                            push_job.status = ST_BAD;
                        end
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        push_job.good = good_next;
        push_job.bad  = bad_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pend_op_reg <= 2'd0;
            left_reg    <= 8'd0;
            sum_reg     <= 8'd0;
            good_reg    <= 16'd0;
            bad_reg     <= 16'd0;
            addr_reg    <= 16'd0;
            len_reg     <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            pend_op_reg <= pend_op_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
        end
    end

endmodule

### src/dlrm_queue.sv
// ----------------------------------------------------------------------------
// dlrm_queue
// Short job queue between front and back end; push and pop may happen in
// the same cycle.
// ----------------------------------------------------------------------------
module dlrm_queue
    import dlrm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### src/dlrm_back.sv
// ----------------------------------------------------------------------------
// dlrm_back
// Back end: expands the job at the queue head into its results, one per
// cycle while the output is ready, into the output register.
// ----------------------------------------------------------------------------
module dlrm_back
    import dlrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_value,
    output logic        out_last,
    output logic [1:0]  out_status,
    output logic [15:0] out_good,
    output logic [15:0] out_bad
);

    logic [2:0]  idx_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  value_reg;
    logic        last_reg;
    logic [1:0]  status_reg;
    logic [15:0] good_reg;
    logic [15:0] bad_reg;
    logic [2:0]  res_cnt;
    logic        res_last;
    logic [1:0]  res_kind;
    logic [7:0]  res_value;
    logic [1:0]  res_status;
    logic        load;

    // number of results of the head job
    always_comb
    begin
        if (head.jtype == JOB_SINGLE)
            res_cnt = 3'd1;
        else if (head.op == OP_READ || head.op == OP_WRITE)
            res_cnt = (head.value == 8'd0) ? 3'd5 : 3'd4;
        else
            res_cnt = 3'd1;
    end

    assign res_last = (idx_reg == res_cnt - 3'd1);

    // result at the current index
    always_comb
    begin
        res_kind   = head.kind;
        res_value  = head.value;
        res_status = head.status;
        if (head.jtype == JOB_HEADER)
        begin
            res_kind   = KIND_TX;
            res_status = ST_GOOD;
            case (idx_reg)
                3'd0:    res_value = {6'd0, head.op} + 8'd1;
                3'd1:    res_value = head.address[7:0];
                3'd2:    res_value = head.address[15:8];
                3'd3:    res_value = head.value;
                default:
                begin
                    res_kind   = KIND_STATUS;
                    res_value  = 8'd0;
                    res_status = ST_ZERO;
                end
            endcase
        end
    end

    assign load = !q_empty && (!valid_reg || out_ready);
    assign pop  = load && res_last;

    // result index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 3'd0;
        else if (load)
            idx_reg <= res_last ? 3'd0 : idx_reg + 3'd1;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= res_kind;
            value_reg  <= res_value;
            last_reg   <= res_last;
            status_reg <= res_status;
            good_reg   <= head.good;
            bad_reg    <= head.bad;
        end
    end

    assign out_valid  = valid_reg;
    assign out_kind   = kind_reg;
    assign out_value  = value_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;
    assign out_good   = good_reg;
    assign out_bad    = bad_reg;

endmodule

### src/debug_link_request_master.sv
// ----------------------------------------------------------------------------
// debug_link_request_master
// Host side of a byte-serial debug link: request, sync wait, opcode and
// header bytes, read/write data with additive checksum, transfer counters.
// ----------------------------------------------------------------------------
// first result of an item is written into a job queue slot, then loaded into
// the output register, from which it can leave when the queue ahead is empty
// throughput: one input item per cycle while the job queue has room
// results leave at one per cycle while the output is ready; a sync item makes
// up to five of them, so the output side can set the sustained item rate
// reset: asynchronous, clears phase, checksum, counters, queue and output
// valid; registers return to attention 0x01 and sync 0x40
module debug_link_request_master
    import dlrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op, address, length, byte_in
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value, status, good_count, bad_count
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    job_t        push_job;
    job_t        head;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic [7:0]  out_value;
    logic [1:0]  out_status;
    logic [15:0] out_good;
    logic [15:0] out_bad;

    // request front end
    dlrm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_op      (s_axis_tdata[1:0]),
        .in_address (s_axis_tdata[17:2]),
        .in_length  (s_axis_tdata[25:18]),
        .in_byte    (s_axis_tdata[33:26]),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue
    dlrm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // result back end
    dlrm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_value  (out_value),
        .out_last   (m_axis_tlast),
        .out_status (out_status),
        .out_good   (out_good),
        .out_bad    (out_bad)
    );

    // output packing
    assign m_axis_tdata = {6'd0, out_bad, out_good, out_status, out_value};

endmodule

### src/dlrm_checker.sv
// ----------------------------------------------------------------------------
// dlrm_checker
// Port-level checks of the debug link request master, bound to the top.
// ----------------------------------------------------------------------------
module dlrm_checker
    import dlrm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    // a status always closes the results of its item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
        else $error("status result not marked last");

    // status field is zero on byte results and value is zero on status
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_STATUS) ?
            (m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[9:8] != 2'd3) :
            (m_axis_tdata[9:8] == ST_GOOD && m_axis_tuser != 2'd3))
        else $error("bad field combination on output");

    // counters never go down between consecutive results
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && $past(m_axis_tvalid) |->
            m_axis_tdata[25:10] >= $past(m_axis_tdata[25:10]) &&
            m_axis_tdata[41:26] >= $past(m_axis_tdata[41:26]))
        else $error("transfer counter decreased");

endmodule

bind debug_link_request_master dlrm_checker u_dlrm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/dlrm_link_checker.sv
// ----------------------------------------------------------------------------
// dlrm_link_checker
// Watches the configuration port and both streams of the debug link request
// master, keeps its own copy of the link protocol state, predicts the results
// of every accepted input transfer and compares each output transfer against
// the oldest prediction. Reports the mismatch count and the number of results
// still awaited, plus a few protocol hints that steer the stimulus.
// ----------------------------------------------------------------------------
module dlrm_link_checker
    import dlrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op, address, length, byte_in
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // value, status, good_count, bad_count
    input  logic [1:0]  m_axis_tuser,   // kind
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          outstanding,
    output logic        awaiting_sync,
    output logic        awaiting_rdata,
    output logic        awaiting_wdata,
    output logic        awaiting_sum,
    output logic [7:0]  sum_now
);

    localparam int MAX_REPORTS = 40;

    typedef enum logic [2:0] {
        LP_IDLE,
        LP_SYNC,
        LP_READ,
        LP_WRITE,
        LP_CHECK
    } link_phase_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic        last;
        logic [1:0]  status;
        logic [15:0] good;
        logic [15:0] bad;
    } link_result_t;

    // register copies
    logic [7:0]   attn_reg;
    logic [7:0]   sync_reg;

    // protocol state
    link_phase_e  link_phase;
    logic [1:0]   op_pending;
    logic [7:0]   bytes_left;
    logic [7:0]   running_sum;
    logic [15:0]  good_total;
    logic [15:0]  bad_total;
    logic [15:0]  req_addr;
    logic [7:0]   req_len;

    // results of one input transfer, then the queue of awaited results
    link_result_t burst [5];
    int           burst_n;
    link_result_t link_out_q [$];

    assign awaiting_sync  = (link_phase == LP_SYNC);
    assign awaiting_rdata = (link_phase == LP_READ);
    assign awaiting_wdata = (link_phase == LP_WRITE);
    assign awaiting_sum   = (link_phase == LP_CHECK);
    assign sum_now        = running_sum;

    task automatic add_result(input logic [1:0] kind, input logic [7:0] value,
                              input logic [1:0] status);
        burst[burst_n].kind   = kind;
        burst[burst_n].value  = value;
        burst[burst_n].status = status;
        burst_n++;
    endtask

    // advance the link state by one input transfer and queue its results
    task automatic predict_transfer(input logic [1:0] cmd, input logic [1:0] op,
                                    input logic [15:0] addr, input logic [7:0] len,
                                    input logic [7:0] data);
        burst_n = 0;
        case (link_phase)
            LP_IDLE:
            begin
                if (cmd == CMD_REQUEST)
                begin
                    op_pending = op;
                    req_addr   = addr;
                    req_len    = len;
                    add_result(KIND_TX, attn_reg, ST_GOOD);
                    link_phase = LP_SYNC;
                end
            end
            LP_SYNC:
            begin
                if (cmd == CMD_LINK && data == sync_reg)
                begin
                    add_result(KIND_TX, 8'(op_pending) + 8'd1, ST_GOOD);
                    if (op_pending == OP_READ || op_pending == OP_WRITE)
                    begin
                        add_result(KIND_TX, req_addr[7:0], ST_GOOD);
                        add_result(KIND_TX, req_addr[15:8], ST_GOOD);
                        add_result(KIND_TX, req_len, ST_GOOD);
                        if (req_len == 8'd0)
                        begin
                            // zero length ends the request at once
                            add_result(KIND_STATUS, 8'd0, ST_ZERO);
                            link_phase = LP_IDLE;
                        end
                        else
                        begin
                            bytes_left  = req_len;
                            running_sum = req_len;
                            link_phase  = (op_pending == OP_READ) ? LP_READ : LP_WRITE;
                        end
                    end
                    else
                    begin
                        link_phase = LP_IDLE;
                    end
                end
            end
            LP_READ, LP_WRITE:
            begin
                if ((link_phase == LP_READ && cmd == CMD_LINK) ||
                    (link_phase == LP_WRITE && cmd == CMD_WDATA))
                begin
                    add_result((link_phase == LP_READ) ? KIND_RDATA : KIND_TX, data, ST_GOOD);
                    running_sum = running_sum + data;
                    bytes_left  = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        link_phase = LP_CHECK;
                end
            end
            LP_CHECK:
            begin
                if (cmd == CMD_LINK)
                begin
                    if (data == running_sum)
                    begin
                        if (good_total != COUNT_MAX)
                            good_total++;
                        add_result(KIND_STATUS, 8'd0, ST_GOOD);
                    end
                    else
                    begin
                        if (bad_total != COUNT_MAX)
                            bad_total++;
                        add_result(KIND_STATUS, 8'd0, ST_BAD);
                    end
                    link_phase = LP_IDLE;
                end
            end
            default:
            begin
                link_phase = LP_IDLE;
            end
        endcase

        // counters after this transfer ride on every result
        for (int k = 0; k < burst_n; k++)
        begin
            burst[k].good = good_total;
            burst[k].bad  = bad_total;
            burst[k].last = (k == burst_n - 1);
            link_out_q.push_back(burst[k]);
        end
    endtask

    // compare one output transfer with the oldest awaited result
    task automatic check_result;
        link_result_t want;
        link_result_t got;
        got.kind   = m_axis_tuser;
        got.value  = m_axis_tdata[7:0];
        got.last   = m_axis_tlast;
        got.status = m_axis_tdata[9:8];
        got.good   = m_axis_tdata[25:10];
        got.bad    = m_axis_tdata[41:26];
        if (link_out_q.size() == 0)
        begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: expected none, actual kind %0d value %02h last %0d %s",
                         $time, got.kind, got.value, got.last,
                         $sformatf("status %0d good %0d bad %0d",
                                   got.status, got.good, got.bad));
            mismatches++;
        end
        else
        begin
            want = link_out_q.pop_front();
            if (got.kind !== want.kind || got.value !== want.value ||
                got.last !== want.last || got.status !== want.status ||
                got.good !== want.good || got.bad !== want.bad)
            begin
                if (mismatches < MAX_REPORTS)
                begin
                    $display("%0t: expected kind %0d value %02h last %0d status %0d good %0d bad %0d",
                             $time, want.kind, want.value, want.last, want.status,
                             want.good, want.bad);
                    $display("%0t: actual   kind %0d value %02h last %0d status %0d good %0d bad %0d",
                             $time, got.kind, got.value, got.last, got.status,
                             got.good, got.bad);
                end
                mismatches++;
            end
        end
    endtask

    // sample everything at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attn_reg    = ATTN_RESET;
            sync_reg    = SYNC_RESET;
            link_phase  = LP_IDLE;
            op_pending  = OP_STEP;
            bytes_left  = 8'd0;
            running_sum = 8'd0;
            good_total  = 16'd0;
            bad_total   = 16'd0;
            req_addr    = 16'd0;
            req_len     = 8'd0;
            mismatches  = 0;
            link_out_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                predict_transfer(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[17:2],
                                 s_axis_tdata[25:18], s_axis_tdata[33:26]);
            // a register write at this edge counts for later transfers
            if (cfg_we)
            begin
                if (cfg_index == CFG_ATTN)
                    attn_reg = cfg_wdata;
                else
                    sync_reg = cfg_wdata;
            end
            outstanding = link_out_q.size();
        end
    end

endmodule

### tb/debug_link_request_master_tb.sv
// ----------------------------------------------------------------------------
// debug_link_request_master_tb
// Drives requests, link bytes and write data into the debug link request
// master: a directed opening over every opcode, zero length, stray items and
// good and bad checksums, then random request sequences under three register
// settings and three idling mixes, one of them with a long output stall.
// ----------------------------------------------------------------------------
module debug_link_request_master_tb
    import dlrm_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // op, address, length, byte_in
    logic [1:0]  s_axis_tuser;   // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // value, status, good_count, bad_count
    logic [1:0]  m_axis_tuser;   // kind
    logic        m_axis_tlast;

    int          mismatches;
    int          outstanding;
    logic        awaiting_sync;
    logic        awaiting_rdata;
    logic        awaiting_wdata;
    logic        awaiting_sum;
    logic [7:0]  sum_now;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          rx_hold_cycles;
    int          cycle_count;
    logic [7:0]  sync_value;

    debug_link_request_master u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dlrm_link_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .awaiting_sync  (awaiting_sync),
        .awaiting_rdata (awaiting_rdata),
        .awaiting_wdata (awaiting_wdata),
        .awaiting_sum   (awaiting_sum),
        .sum_now        (sum_now)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // output side: random stalls, or a long hold-off when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // one input transfer; starts and ends at a falling edge
    task automatic send_item(input logic [1:0] cmd, input logic [1:0] op,
                             input logic [15:0] addr, input logic [7:0] len,
                             input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, data, len, addr, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        if (idx == CFG_SYNC)
            sync_value = val;
    endtask

    // bring the open request to its end, then wait for the block to drain
    task automatic finish_request;
        while (awaiting_sync || awaiting_rdata || awaiting_wdata || awaiting_sum)
        begin
            if (awaiting_sync)
                send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, sync_value);
            else if (awaiting_wdata)
                send_item(CMD_WDATA, OP_STEP, 16'd0, 8'd0, 8'($urandom_range(0, 255)));
            else if (awaiting_sum)
                send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, sum_now);
            else
                send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'($urandom_range(0, 255)));
        end
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly well-formed request sequences with random content, some noise
    task automatic random_requests(input int count);
        int          sent;
        int          pick;
        int          len_pick;
        logic [1:0]  op;
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  data;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            op   = 2'($urandom_range(0, 3));
            addr = 16'($urandom_range(0, 65535));
            len  = 8'($urandom_range(0, 255));
            data = 8'($urandom_range(0, 255));
            if (pick < 6)
            begin
                // stray item of any kind
                send_item(2'($urandom_range(0, 3)), op, addr, len, data);
            end
            else if (awaiting_sync)
            begin
                if (pick < 30)
                begin
                    // line noise ahead of the sync byte
                    send_item(CMD_LINK, op, addr, len, data);
                end
                else
                begin
                    send_item(CMD_LINK, op, addr, len, sync_value);
                    sent++;
                end
            end
            else if (awaiting_rdata)
            begin
                send_item(CMD_LINK, op, addr, len, data);
                sent++;
            end
            else if (awaiting_wdata)
            begin
                send_item(CMD_WDATA, op, addr, len, data);
                sent++;
            end
            else if (awaiting_sum)
            begin
                send_item(CMD_LINK, op, addr, len, (pick < 80) ? sum_now : data);
                sent++;
            end
            else
            begin
                // new request; data transfers mostly short
                if (op == OP_READ || op == OP_WRITE)
                begin
                    len_pick = $urandom_range(0, 99);
                    if (len_pick < 8)
                        len = 8'd0;
                    else if (len_pick < 90)
                        len = 8'($urandom_range(1, 6));
                    else
                        len = 8'($urandom_range(7, 40));
                end
                send_item(CMD_REQUEST, op, addr, len, data);
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ATTN;
        cfg_wdata      = 8'd0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_REQUEST;
        send_idle_pct  = 20;
        recv_idle_pct  = 65;
        rx_hold_cycles = 0;
        sync_value     = SYNC_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // stray items while idle
        send_item(2'd3, OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        send_item(CMD_WDATA, OP_STEP, 16'd0, 8'd0, 8'h5A);
        // step, with a second request ignored and a noise byte before sync
        send_item(CMD_REQUEST, OP_STEP, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_REQUEST, OP_RUN, 16'h1234, 8'h10, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'h3F);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        // run with zero length goes back to idle after the opcode
        send_item(CMD_REQUEST, OP_RUN, 16'h0000, 8'h00, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        // read of two bytes, stray write data, good checksum
        send_item(CMD_REQUEST, OP_READ, 16'hA5C3, 8'd2, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        send_item(CMD_WDATA, OP_STEP, 16'd0, 8'd0, 8'h12);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'hFF);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'h01);
        // write of one byte, stray link and data bytes, bad checksum
        send_item(CMD_REQUEST, OP_WRITE, 16'hFFFF, 8'd1, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'h77);
        send_item(CMD_WDATA, OP_STEP, 16'd0, 8'd0, 8'hFF);
        send_item(CMD_WDATA, OP_STEP, 16'd0, 8'd0, 8'h33);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, 8'h55);
        // zero length read and write
        send_item(CMD_REQUEST, OP_READ, 16'h1234, 8'd0, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        send_item(CMD_REQUEST, OP_WRITE, 16'h0000, 8'd0, 8'h00);
        send_item(CMD_LINK, OP_STEP, 16'd0, 8'd0, SYNC_RESET);
        finish_request();

        // extremes: all-ones attention, zero sync
        write_reg(CFG_ATTN, 8'hFF);
        write_reg(CFG_SYNC, 8'h00);
        random_requests(80);
        finish_request();

        // other extremes, idling swapped
        send_idle_pct = 65;
        recv_idle_pct = 20;
        write_reg(CFG_ATTN, 8'h00);
        write_reg(CFG_SYNC, 8'hFF);
        random_requests(80);
        finish_request();

        // random registers, no idling, long output hold-off at the start
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ATTN, 8'($urandom_range(0, 255)));
        write_reg(CFG_SYNC, 8'($urandom_range(0, 255)));
        rx_hold_cycles = HOLD_CYCLES;
        random_requests(90);
        finish_request();

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
